FILE: rtl/assert_macros.svh
// Assertion helpers used by the parser module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define UFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define UFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/ufd_pkg.sv
// ----------------------------------------------------------------------------
// ufd_pkg
// Types, limits and name tables of the URL form field decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ufd_pkg;

    localparam logic [10:0] MAX_BODY     = 11'd512;
    localparam logic [2:0]  MAX_PAIRS    = 3'd4;
    localparam logic [10:0] BYTE_SAT     = 11'd1023;
    localparam logic [3:0]  NAME_LEN_SAT = 4'd15;
    localparam logic [3:0]  SEEN_ALL     = 4'hF;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    localparam logic [7:0] FIELD_CAP [4] = '{8'd17, 8'd33, 8'd64, 8'd65};
    localparam logic [3:0] NAME_LEN  [4] = '{4'd4, 4'd9, 4'd13, 4'd8};

    localparam logic [103:0] NAMES [4] = '{
        {72'h0, "csrf"},
        {32'h0, "wifi_", "ssid"},
        {"wifi_", "password"},
        {40'h0, "timezone"}
    };

    typedef enum logic [2:0] {
        ESC_NONE = 3'b001,
        ESC_HIGH = 3'b010,
        ESC_LOW  = 3'b100
    } t_esc;

    typedef struct packed {
        logic       char_valid;
        logic [1:0] field_id;
        logic [6:0] decoded_char;
        logic       done_res;
        logic       accepted;
    } t_result;

    function automatic logic [7:0] name_char(input logic [1:0] f, input logic [3:0] pos);
        logic [3:0] k;
        k = NAME_LEN[f] - 4'd1 - pos;
        return NAMES[f][{k, 3'b000} +: 8];
    endfunction

    // {ok, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ufd_in_stage.sv
// ----------------------------------------------------------------------------
// ufd_in_stage
// Input register for one raw body byte and its end marker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ufd_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    input  wire logic       i_take,
    output logic            o_valid,
    output logic [7:0]      o_data_byte,
    output logic            o_last_byte
);

    logic       r_valid;
    logic [7:0] r_data;
    logic       r_last;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    assign o_valid     = r_valid;
    assign o_data_byte = r_data;
    assign o_last_byte = r_last;

endmodule

`default_nettype wire

FILE: rtl/ufd_parser.sv
// ----------------------------------------------------------------------------
// ufd_parser
// Parse state and single-pass decode of one byte into one result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ufd_parser (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output ufd_pkg::t_result o_result
);

    import ufd_pkg::*;

    logic        r_in_value,  n_in_value;
    logic        r_at_start,  n_at_start;
    logic [3:0]  r_name_len,  n_name_len;
    logic [3:0]  r_name_match, n_name_match;
    t_esc        r_esc,       n_esc;
    logic [3:0]  r_high,      n_high;
    logic [1:0]  r_field,     n_field;
    logic [6:0]  r_chars,     n_chars;
    logic [3:0]  r_seen,      n_seen;
    logic [2:0]  r_pairs,     n_pairs;
    logic [9:0]  r_bytes,     n_bytes;
    logic        r_failed,    n_failed;

    always_comb begin
        logic [10:0] cnt;
        logic        fail;
        logic        emit_req;
        logic [7:0]  emit_val;
        logic [4:0]  hx;
        logic [7:0]  next_chars;
        logic [1:0]  hit;
        logic        hit_ok;

        n_in_value   = r_in_value;
        n_at_start   = r_at_start;
        n_name_len   = r_name_len;
        n_name_match = r_name_match;
        n_esc        = r_esc;
        n_high       = r_high;
        n_field      = r_field;
        n_chars      = r_chars;
        n_seen       = r_seen;
        n_pairs      = r_pairs;
        fail         = r_failed;
        emit_req     = 1'b0;
        emit_val     = 8'h00;
        hit          = 2'd0;
        hit_ok       = 1'b0;
        o_result     = '0;

        cnt = {1'b0, r_bytes} + 11'd1;
        if (cnt > MAX_BODY) begin
            fail = 1'b1;
        end
        n_bytes = (cnt > BYTE_SAT) ? BYTE_SAT[9:0] : cnt[9:0];
        hx = hex_digit(i_data_byte);

        if (!fail) begin
            if (r_in_value) begin
                case (r_esc)
                    ESC_HIGH: begin
                        if (!hx[4]) begin
                            fail = 1'b1;
                        end else begin
                            n_high = hx[3:0];
                            n_esc  = ESC_LOW;
                        end
                    end
                    ESC_LOW: begin
                        n_esc = ESC_NONE;
                        if (!hx[4]) begin
                            fail = 1'b1;
                        end else begin
                            emit_req = 1'b1;
                            emit_val = {r_high, hx[3:0]};
                        end
                    end
                    default: begin
                        if (i_data_byte == CH_AMP) begin
                            n_in_value   = 1'b0;
                            n_at_start   = 1'b1;
                            n_name_len   = 4'd0;
                            n_name_match = 4'hF;
                            n_esc        = ESC_NONE;
                            n_high       = 4'd0;
                            n_chars      = 7'd0;
                        end else if (i_data_byte == CH_PCT) begin
                            n_esc = ESC_HIGH;
                        end else if (i_data_byte == CH_PLUS) begin
                            emit_req = 1'b1;
                            emit_val = CH_SPACE;
                        end else begin
                            emit_req = 1'b1;
                            emit_val = i_data_byte;
                        end
                    end
                endcase
            end else begin
                if (r_at_start) begin
                    n_at_start = 1'b0;
                    if (r_pairs >= MAX_PAIRS) begin
                        fail = 1'b1;
                    end else begin
                        n_pairs = r_pairs + 3'd1;
                    end
                end
                if (fail) begin
                    n_pairs = n_pairs;
                end else if (i_data_byte == CH_AMP) begin
                    fail = 1'b1;
                end else if (i_data_byte == CH_EQ) begin
                    for (int i = 0; i < 4; i++) begin
                        if (r_name_match[i] && r_name_len == NAME_LEN[i]) begin
                            hit    = 2'(i);
                            hit_ok = 1'b1;
                        end
                    end
                    if (r_name_len == 4'd0 || !hit_ok || r_seen[hit]) begin
                        fail = 1'b1;
                    end else begin
                        n_field      = hit;
                        n_seen[hit]  = 1'b1;
                        n_in_value   = 1'b1;
                        n_chars      = 7'd0;
                        n_esc        = ESC_NONE;
                    end
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        if (r_name_len >= NAME_LEN[i] ||
                            name_char(2'(i), r_name_len) != i_data_byte) begin
                            n_name_match[i] = 1'b0;
                        end
                    end
                    if (r_name_len < NAME_LEN_SAT) begin
                        n_name_len = r_name_len + 4'd1;
                    end
                end
            end
        end

        next_chars = {1'b0, r_chars} + 8'd1;
        if (emit_req) begin
            if (emit_val < CH_SPACE || emit_val > CH_TILDE ||
                next_chars >= FIELD_CAP[r_field]) begin
                fail = 1'b1;
            end else begin
                n_chars               = next_chars[6:0];
                o_result.char_valid   = 1'b1;
                o_result.field_id     = r_field;
                o_result.decoded_char = emit_val[6:0];
            end
        end

        o_result.done_res = i_last_byte;
        if (i_last_byte) begin
            if ((!n_in_value && !n_at_start) || n_esc != ESC_NONE) begin
                fail = 1'b1;
            end
            o_result.accepted = !fail && (n_seen == SEEN_ALL);
            n_in_value   = 1'b0;
            n_at_start   = 1'b1;
            n_name_len   = 4'd0;
            n_name_match = 4'hF;
            n_esc        = ESC_NONE;
            n_high       = 4'd0;
            n_field      = 2'd0;
            n_chars      = 7'd0;
            n_seen       = 4'd0;
            n_pairs      = 3'd0;
            n_bytes      = 10'd0;
            fail         = 1'b0;
        end
        n_failed = fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_value   <= 1'b0;
            r_at_start   <= 1'b1;
            r_name_len   <= 4'd0;
            r_name_match <= 4'hF;
            r_esc        <= ESC_NONE;
            r_high       <= 4'd0;
            r_field      <= 2'd0;
            r_chars      <= 7'd0;
            r_seen       <= 4'd0;
            r_pairs      <= 3'd0;
            r_bytes      <= 10'd0;
            r_failed     <= 1'b0;
        end else if (i_step) begin
            r_in_value   <= n_in_value;
            r_at_start   <= n_at_start;
            r_name_len   <= n_name_len;
            r_name_match <= n_name_match;
            r_esc        <= n_esc;
            r_high       <= n_high;
            r_field      <= n_field;
            r_chars      <= n_chars;
            r_seen       <= n_seen;
            r_pairs      <= n_pairs;
            r_bytes      <= n_bytes;
            r_failed     <= n_failed;
        end
    end

    `UFD_ASSERT_IMPL(a_char_printable, i_clk, i_rst_n, i_step && o_result.char_valid,
        o_result.decoded_char >= 7'h20 && o_result.decoded_char <= 7'h7E)
    `UFD_ASSERT_IMPL(a_no_char_after_fail, i_clk, i_rst_n, i_step && r_failed,
        !o_result.char_valid && !o_result.accepted)
    `UFD_ASSERT_NEXT(a_body_end_clears, i_clk, i_rst_n, i_step && i_last_byte,
        r_bytes == 10'd0 && r_seen == 4'd0 && !r_failed && r_at_start)
    `UFD_ASSERT_NEXT(a_seen_only_grows, i_clk, i_rst_n, i_step && !i_last_byte,
        (r_seen & $past(r_seen)) == $past(r_seen))

endmodule

`default_nettype wire

FILE: rtl/ufd_out_stage.sv
// ----------------------------------------------------------------------------
// ufd_out_stage
// Result register; holds one decoded result until the consumer takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ufd_out_stage (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire ufd_pkg::t_result i_result,
    output logic                 o_free,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output ufd_pkg::t_result     o_result
);

    import ufd_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

FILE: rtl/url_form_field_decoder_core.sv
// ----------------------------------------------------------------------------
// url_form_field_decoder_core
// URL-encoded form body decoder for four fixed field names.
// ----------------------------------------------------------------------------
// One body byte goes in per request and exactly one result comes out for it:
// a decoded value character tagged with its field, and on the final byte the
// accept/reject verdict for the whole body. Throughput is one byte per clock
// while results are taken; a byte passes the input register, then one decode
// pass that updates the parse state and loads the result register. Parse state
// returns to reset after each final byte, so the next byte opens a new body.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module url_form_field_decoder_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_char_valid,
    output logic [1:0]      o_field_id,
    output logic [6:0]      o_decoded_char,
    output logic            o_done_res,
    output logic            o_accepted
);

    import ufd_pkg::*;

    logic       in_valid;
    logic [7:0] in_data;
    logic       in_last;
    logic       out_free;
    logic       step;
    t_result    step_result;
    t_result    out_result;

    assign step = in_valid && out_free;

    ufd_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_take      (step),
        .o_valid     (in_valid),
        .o_data_byte (in_data),
        .o_last_byte (in_last)
    );

    ufd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_data_byte (in_data),
        .i_last_byte (in_last),
        .o_result    (step_result)
    );

    ufd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (step_result),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    assign o_char_valid   = out_result.char_valid;
    assign o_field_id     = out_result.field_id;
    assign o_decoded_char = out_result.decoded_char;
    assign o_done_res     = out_result.done_res;
    assign o_accepted     = out_result.accepted;

endmodule

`default_nettype wire

FILE: verif/url_form_field_decoder_core_test.sv
// ----------------------------------------------------------------------------
// url_form_field_decoder_core_test
// Self-checking bench for the URL form field decoder. Form bodies go in one
// byte per request: hand-written bodies for each rule and error, a body at
// the length limit, then random well-formed, damaged and noise bodies. An
// in-bench decoder predicts every result, and each result that comes back
// is checked field by field against the oldest prediction. Both sides idle
// at random; one phase holds the receiver off and one drains mid-body.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module url_form_field_decoder_core_test;

    import ufd_pkg::*;

    typedef logic [7:0] t_bytes [$];

    typedef enum logic [1:0] {
        FLD_CSRF = 2'd0,
        FLD_SSID = 2'd1,
        FLD_PASS = 2'd2,
        FLD_ZONE = 2'd3
    } t_field;

    localparam string NET_KEY          = {"wifi_", "ssid"};
    localparam string PASS_KEY         = {"wifi_", "password"};
    localparam int    FIELD_CAPS [4]   = '{17, 33, 64, 65};
    localparam string FIELD_NAMES [4]  = '{"csrf", NET_KEY, PASS_KEY, "timezone"};
    localparam int    SINK_HOLD_CYCLES = 200;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_last_byte = 1'b0;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic       o_char_valid;
    logic [1:0] o_field_id;
    logic [6:0] o_decoded_char;
    logic       o_done_res;
    logic       o_accepted;

    url_form_field_decoder_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_char_valid   (o_char_valid),
        .o_field_id     (o_field_id),
        .o_decoded_char (o_decoded_char),
        .o_done_res     (o_done_res),
        .o_accepted     (o_accepted)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Decoder state of the bench
    logic       in_val;
    logic       pair_fresh;
    int         name_pos;
    logic [3:0] name_cand;
    t_esc       esc;
    logic [3:0] esc_hi;
    t_field     field_sel;
    int         value_chars;
    logic [3:0] fields_seen;
    int         pairs_used;
    int         body_bytes;
    logic       body_bad;

    t_result pending_decodes [$];
    int      fail_count = 0;
    int      bytes_sent = 0;
    bit      src_idle_on = 1'b1;
    bit      sink_idle_on = 1'b1;
    bit      sink_held = 1'b0;
    int      sink_wait = 0;
    event    sink_hold_ev;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic void clear_pair();
        in_val      = 1'b0;
        pair_fresh  = 1'b1;
        name_pos    = 0;
        name_cand   = 4'hF;
        esc         = ESC_NONE;
        esc_hi      = 4'h0;
        value_chars = 0;
    endfunction

    function automatic void clear_body();
        clear_pair();
        field_sel   = FLD_CSRF;
        fields_seen = 4'h0;
        pairs_used  = 0;
        body_bytes  = 0;
        body_bad    = 1'b0;
    endfunction

    function automatic t_result emit_char(input logic [7:0] v);
        t_result r;
        r = '0;
        if (v < CH_SPACE || v > CH_TILDE || value_chars + 1 >= FIELD_CAPS[field_sel]) begin
            body_bad = 1'b1;
        end else begin
            value_chars++;
            r.char_valid   = 1'b1;
            r.field_id     = field_sel;
            r.decoded_char = v[6:0];
        end
        return r;
    endfunction

    function automatic t_result decode_byte(input logic [7:0] b, input logic last);
        t_result r;
        int      d;
        int      hit;
        int      i;
        r = '0;
        body_bytes++;
        if (body_bytes > MAX_BODY) body_bad = 1'b1;
        if (!body_bad) begin
            if (in_val) begin
                if (esc == ESC_HIGH) begin
                    d = hex_value(b);
                    if (d < 0) body_bad = 1'b1;
                    else begin
                        esc_hi = d[3:0];
                        esc    = ESC_LOW;
                    end
                end else if (esc == ESC_LOW) begin
                    d   = hex_value(b);
                    esc = ESC_NONE;
                    if (d < 0) body_bad = 1'b1;
                    else r = emit_char({esc_hi, d[3:0]});
                end else if (b == CH_AMP) begin
                    clear_pair();
                end else if (b == CH_PCT) begin
                    esc = ESC_HIGH;
                end else if (b == CH_PLUS) begin
                    r = emit_char(CH_SPACE);
                end else begin
                    r = emit_char(b);
                end
            end else begin
                if (pair_fresh) begin
                    pair_fresh = 1'b0;
                    if (pairs_used >= MAX_PAIRS) body_bad = 1'b1;
                    else pairs_used++;
                end
                if (body_bad) begin
                end else if (b == CH_AMP) begin
                    body_bad = 1'b1;
                end else if (b == CH_EQ) begin
                    hit = -1;
                    for (i = 0; i < 4; i++) begin
                        if (name_cand[i] && name_pos == FIELD_NAMES[i].len()) hit = i;
                    end
                    if (name_pos == 0 || hit < 0) begin
                        body_bad = 1'b1;
                    end else if (fields_seen[hit]) begin
                        body_bad = 1'b1;
                    end else begin
                        field_sel        = t_field'(hit);
                        fields_seen[hit] = 1'b1;
                        in_val           = 1'b1;
                        value_chars      = 0;
                        esc              = ESC_NONE;
                    end
                end else begin
                    for (i = 0; i < 4; i++) begin
                        if (name_pos >= FIELD_NAMES[i].len()) name_cand[i] = 1'b0;
                        else if (FIELD_NAMES[i][name_pos] != b) name_cand[i] = 1'b0;
                    end
                    if (name_pos < 15) name_pos++;
                end
            end
        end
        r.done_res = last;
        if (last) begin
            if ((!in_val && !pair_fresh) || esc != ESC_NONE) body_bad = 1'b1;
            r.accepted = !body_bad && fields_seen == SEEN_ALL;
            clear_body();
        end
        return r;
    endfunction

    function automatic t_bytes to_bytes(input string s);
        t_bytes q;
        int     k;
        for (k = 0; k < s.len(); k++) q.push_back(s[k]);
        return q;
    endfunction

    function automatic t_bytes make_value(input int fld);
        t_bytes     q;
        int         n;
        int         roll;
        logic [7:0] c;
        roll = $urandom_range(99);
        if (roll < 70) n = $urandom_range(6);
        else if (roll < 90) n = $urandom_range(FIELD_CAPS[fld] - 1);
        else n = FIELD_CAPS[fld] - 1 + $urandom_range(1);
        repeat (n) begin
            roll = $urandom_range(99);
            if (roll < 60) begin
                c = 8'($urandom_range(8'h7e, 8'h20));
                if (c == CH_AMP || c == CH_PCT) c = CH_EQ;
                q.push_back(c);
            end else if (roll < 72) begin
                q.push_back(CH_PLUS);
            end else if (roll < 98) begin
                c = (roll < 95) ? 8'($urandom_range(8'h7e, 8'h20)) : 8'($urandom);
                q.push_back(CH_PCT);
                q.push_back(hex_char(c[7:4]));
                q.push_back(hex_char(c[3:0]));
            end else begin
                q.push_back(8'($urandom));
            end
        end
        return q;
    endfunction

    function automatic t_bytes make_form_body();
        t_bytes body;
        t_bytes val;
        int     order [4];
        int     npairs;
        int     roll;
        int     k;
        int     j;
        int     t;
        roll = $urandom_range(99);
        if (roll < 15) begin
            repeat ($urandom_range(8, 1)) body.push_back(8'($urandom));
            return body;
        end
        order = '{0, 1, 2, 3};
        for (k = 3; k > 0; k--) begin
            j        = $urandom_range(k);
            t        = order[k];
            order[k] = order[j];
            order[j] = t;
        end
        npairs = (roll >= 60 && roll < 68) ? $urandom_range(3, 1) : 4;
        for (k = 0; k <= npairs; k++) begin
            if (k == npairs) begin
                if (!(roll >= 68 && roll < 76)) break;
                t = $urandom_range(3);
            end else begin
                t = order[k];
            end
            if (k > 0) body.push_back(CH_AMP);
            for (j = 0; j < FIELD_NAMES[t].len(); j++) body.push_back(FIELD_NAMES[t][j]);
            body.push_back(CH_EQ);
            val  = make_value(t);
            body = {body, val};
        end
        if (roll >= 76 && roll < 84) begin
            body[$urandom_range(body.size() - 1)] = 8'($urandom);
        end else if (roll >= 84 && roll < 92) begin
            t = $urandom_range(body.size() - 1, 1);
            while (body.size() > t) void'(body.pop_back());
        end else if ($urandom_range(5) == 0) begin
            body.push_back(CH_AMP);
        end
        return body;
    endfunction

    // Fill every field to one below its capacity; 148 escapes give 512 bytes.
    function automatic t_bytes make_full_body(input int n_escaped);
        t_bytes     body;
        int         f;
        int         j;
        int         n;
        logic [7:0] c;
        n = 0;
        for (f = 0; f < 4; f++) begin
            if (f > 0) body.push_back(CH_AMP);
            for (j = 0; j < FIELD_NAMES[f].len(); j++) body.push_back(FIELD_NAMES[f][j]);
            body.push_back(CH_EQ);
            for (j = 0; j < FIELD_CAPS[f] - 1; j++) begin
                if (n < n_escaped) begin
                    c = 8'h20 + 8'(n % 95);
                    body.push_back(CH_PCT);
                    body.push_back(hex_char(c[7:4]));
                    body.push_back(hex_char(c[3:0]));
                end else begin
                    body.push_back(8'h61 + 8'(n % 26));
                end
                n++;
            end
        end
        return body;
    endfunction

    task automatic send_request(input logic [7:0] b, input logic last);
        int gap;
        gap = src_idle_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_data_byte = b;
        i_last_byte = last;
        do @(posedge i_clk); while (!o_ready);
        pending_decodes.push_back(decode_byte(b, last));
        bytes_sent++;
    endtask

    task automatic send_body(input t_bytes body);
        int k;
        for (k = 0; k < body.size(); k++) send_request(body[k], k == body.size() - 1);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_decodes.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random stalls, or a long hold when asked
    initial forever begin
        @(sink_hold_ev);
        sink_held = 1'b1;
        repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
        sink_held = 1'b0;
    end

    always @(negedge i_clk) begin
        if (sink_held) begin
            i_ready <= 1'b0;
        end else if (sink_wait > 0) begin
            i_ready   <= 1'b0;
            sink_wait <= sink_wait - 1;
        end else begin
            i_ready   <= 1'b1;
            sink_wait <= sink_idle_on ? pick_gap() : 0;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_decodes.size() == 0) begin
                $error("result with no request pending");
                fail_count++;
            end else begin
                want = pending_decodes.pop_front();
                if (o_char_valid !== want.char_valid) begin
                    $error("char_valid: expected %0d, got %0d", want.char_valid, o_char_valid);
                    fail_count++;
                end
                if (o_field_id !== want.field_id) begin
                    $error("field_id: expected %0d, got %0d", want.field_id, o_field_id);
                    fail_count++;
                end
                if (o_decoded_char !== want.decoded_char) begin
                    $error("decoded_char: expected 0x%02h, got 0x%02h",
                           want.decoded_char, o_decoded_char);
                    fail_count++;
                end
                if (o_done_res !== want.done_res) begin
                    $error("done_res: expected %0d, got %0d", want.done_res, o_done_res);
                    fail_count++;
                end
                if (o_accepted !== want.accepted) begin
                    $error("accepted: expected %0d, got %0d", want.accepted, o_accepted);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_directed_bodies();
        t_bytes body;
        int     n;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send_body(to_bytes({"csrf=t0k&", NET_KEY, "=My+Net&", PASS_KEY,
                            "=p%41%7e%2b%3D=x&timezone=UTC%2B1"}));
        send_body(to_bytes({"timezone=a&csrf=b&", PASS_KEY, "=c&", NET_KEY, "=d&"}));
        send_body(to_bytes({"csrf=~ &", NET_KEY, "=&", PASS_KEY, "=%20&timezone=%7E"}));
        send_body(to_bytes("=x"));
        send_body(to_bytes("csrfx=1"));
        send_body(to_bytes("csr=1"));
        send_body(to_bytes("csrf&"));
        send_body(to_bytes("wifi"));
        send_body(to_bytes("csrf=a&csrf=b"));
        send_body(to_bytes({"csrf=1&", NET_KEY, "=2&", PASS_KEY, "=3&timezone=4&x"}));
        send_body(to_bytes("csrf=%4g"));
        send_body(to_bytes("csrf=%G1"));
        send_body(to_bytes("csrf=%4"));
        send_body(to_bytes("csrf=%"));
        send_body(to_bytes("csrf=%1F"));
        send_body(to_bytes("csrf=%7F"));
        send_body(to_bytes("csrf=%ff"));
        for (n = 16; n <= 17; n++) begin
            body = to_bytes("csrf=");
            repeat (n) body.push_back("x");
            send_body(body);
        end
        body = to_bytes("csrf=");
        body.push_back(8'h00);
        send_body(body);
        body = '{8'hFF, CH_EQ, 8'h31};
        send_body(body);
        send_body(to_bytes("&"));
        send_body(to_bytes("a"));
        send_body(to_bytes("csrf="));
    endtask

    // Bytes 512, 513 and 514 are plain value characters: the first still counts
    task automatic test_body_limit();
        send_body(make_full_body(149));
    endtask

    task automatic test_random_bodies();
        int stop_at;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        stop_at      = bytes_sent + 80;
        while (bytes_sent < stop_at) send_body(make_form_body());
    endtask

    task automatic test_back_to_back();
        int stop_at;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        stop_at      = bytes_sent + 20;
        while (bytes_sent < stop_at) send_body(make_form_body());
    endtask

    task automatic test_receiver_hold();
        int stop_at;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b1;
        stop_at      = bytes_sent + 20;
        -> sink_hold_ev;
        while (bytes_sent < stop_at) send_body(make_form_body());
    endtask

    task automatic test_sender_pause();
        t_bytes body;
        int     cut;
        int     k;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        do body = make_form_body(); while (body.size() < 2);
        cut = body.size() / 2;
        for (k = 0; k < body.size(); k++) begin
            if (k == cut && k > 0) drain_results();
            send_request(body[k], k == body.size() - 1);
        end
    endtask

    initial begin
        clear_body();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_bodies();
        test_body_limit();
        test_random_bodies();
        test_back_to_back();
        test_receiver_hold();
        test_sender_pause();

        drain_results();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/ufd_pkg.sv
rtl/ufd_in_stage.sv
rtl/ufd_parser.sv
rtl/ufd_out_stage.sv
rtl/url_form_field_decoder_core.sv
verif/url_form_field_decoder_core_test.sv
